// ----- rtl/core/sclru_pkg.sv -----
// Shared types and constants of the sector cache LRU tag engine.
`timescale 1ns / 1ps

package sclru_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LEAVES  = 1 << IDX_W;
  localparam int unsigned HALF    = LEAVES / 2;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned TAG_W   = 22;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CMD_W   = 2;

  localparam logic [AGE_W-1:0] AGE_EMPTY = '0;
  localparam logic [AGE_W-1:0] AGE_LIMIT = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_INVAL = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TAG_W-1:0] sector;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fetch_needed;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/sclru_ctrl.sv -----
// Controller state machine of the sector cache LRU tag engine.
`timescale 1ns / 1ps

module sclru_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sclru_pkg::ctrl_cmd_t cmd_o
);
  import sclru_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_room;

  assign out_room      = !out_valid_q || !out_stall_i;
  assign cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == ST_UPD) && out_room;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/sclru_dpath.sv -----
// Datapath of the sector cache LRU tag engine: entries, tag compare, age tree, counter.
`timescale 1ns / 1ps

module sclru_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sclru_pkg::ctrl_cmd_t cmd_i,
  input  sclru_pkg::in_t       in_i,
  output sclru_pkg::out_t      out_o
);
  import sclru_pkg::*;

  // Entry state.
  logic [AGE_W-1:0] age_q [ENTRIES];
  logic [AGE_W-1:0] age_d [ENTRIES];
  logic [TAG_W-1:0] tag_q [ENTRIES];
  logic [TAG_W-1:0] tag_d [ENTRIES];
  logic [AGE_W-1:0] ctr_q, ctr_d;

  // Lookup results held between the two steps of an item.
  logic [CMD_W-1:0] cmd_q;
  logic [TAG_W-1:0] sector_q;
  logic             vhit_q, vhit_d;
  logic [IDX_W-1:0] vidx_q, vidx_d;
  logic             thit_q, thit_d;
  logic [IDX_W-1:0] tidx_q, tidx_d;
  logic [AGE_W-1:0] l1_age_q [HALF];
  logic [AGE_W-1:0] l1_age_d [HALF];
  logic [IDX_W-1:0] l1_idx_q [HALF];
  logic [IDX_W-1:0] l1_idx_d [HALF];

  out_t out_q, out_d;

  // First valid match and first tag match on the incoming sector, plus the
  // first level of the minimum-age tree. Unused leaves read as the limit so
  // that a lower index wins every tie.
  always_comb begin
    logic [AGE_W-1:0] lf_age [LEAVES];
    vhit_d = 1'b0;
    vidx_d = '0;
    thit_d = 1'b0;
    tidx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tag_q[i] == in_i.sector) begin
        thit_d = 1'b1;
        tidx_d = IDX_W'(i);
        if (age_q[i] != AGE_EMPTY) begin
          vhit_d = 1'b1;
          vidx_d = IDX_W'(i);
        end
      end
    end
    for (int i = 0; i < LEAVES; i++) begin
      lf_age[i] = (i < ENTRIES) ? age_q[i] : AGE_LIMIT;
    end
    for (int p = 0; p < HALF; p++) begin
      if (lf_age[2*p+1] < lf_age[2*p]) begin
        l1_age_d[p] = lf_age[2*p+1];
        l1_idx_d[p] = IDX_W'(2*p+1);
      end else begin
        l1_age_d[p] = lf_age[2*p];
        l1_idx_d[p] = IDX_W'(2*p);
      end
    end
  end

  // Second step: finish the tree, then refresh, allocate or invalidate.
  always_comb begin
    logic [AGE_W-1:0] red_age [HALF];
    logic [IDX_W-1:0] red_idx [HALF];
    logic [AGE_W-1:0] stamp;
    red_age = l1_age_q;
    red_idx = l1_idx_q;
    for (int s = HALF / 2; s >= 1; s = s / 2) begin
      for (int p = 0; p < s; p++) begin
        if (red_age[2*p+1] < red_age[2*p]) begin
          red_age[p] = red_age[2*p+1];
          red_idx[p] = red_idx[2*p+1];
        end else begin
          red_age[p] = red_age[2*p];
          red_idx[p] = red_idx[2*p];
        end
      end
    end
    stamp = ctr_q + AGE_W'(1);

    age_d = age_q;
    tag_d = tag_q;
    ctr_d = ctr_q;
    out_d = '0;

    if ((cmd_q == CMD_READ) || (cmd_q == CMD_WRITE)) begin
      if (vhit_q) begin
        age_d[vidx_q] = stamp;
        ctr_d         = stamp;
        out_d.hit     = 1'b1;
        out_d.slot    = SLOT_W'(vidx_q);
      end else if (cmd_q == CMD_READ) begin
        age_d[red_idx[0]]  = stamp;
        tag_d[red_idx[0]]  = sector_q;
        ctr_d              = stamp;
        out_d.slot         = SLOT_W'(red_idx[0]);
        out_d.fetch_needed = 1'b1;
      end
    end else if (cmd_q == CMD_INVAL) begin
      if (thit_q) begin
        age_d[tidx_q] = AGE_EMPTY;
        out_d.hit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= AGE_EMPTY;
        tag_q[i] <= '0;
      end
      ctr_q <= '0;
    end else if (cmd_i.commit) begin
      age_q <= age_d;
      tag_q <= tag_d;
      ctr_q <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= in_i.cmd;
      sector_q <= in_i.sector;
      vhit_q   <= vhit_d;
      vidx_q   <= vidx_d;
      thit_q   <= thit_d;
      tidx_q   <= tidx_d;
      l1_age_q <= l1_age_d;
      l1_idx_q <= l1_idx_d;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ----- rtl/core/sector_cache_lru_tags.sv -----
// Top level of the sector cache LRU tag engine.
`timescale 1ns / 1ps
//
// Tag and replacement engine for a small fully associative sector cache.
// A lookup beat on the input channel carries a command (read with allocate,
// write without allocate, or invalidate) and a sector number. Each accepted
// beat yields exactly one result beat with hit, slot and fetch_needed.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. One item is in work at a time: the input is stalled while
// an accepted beat is updated, so a new beat cannot be taken until the
// last one is committed. The compare step checks every tag in parallel and
// registers the first level of the minimum-age tree; the update step
// finishes the tree, updates the entry ages, tags and use counter, and loads
// the output register. The result is valid in the cycle after the commit.
// If the receiver stalls with a result still held, the update waits until
// the output register frees, and the input stays stalled meanwhile; a result
// that is waiting does not block the next input beat once it is committed.
// Reset empties every entry, clears all tags to zero, zeroes the counter
// and drops any pending result.

module sector_cache_lru_tags (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sclru_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sclru_pkg::out_t out_o
);
  import sclru_pkg::*;

  ctrl_cmd_t ctl;

  // The controller sequences each item through compare and update.
  sclru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (ctl)
  );

  // The datapath holds the entries and produces the result beat.
  sclru_dpath u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (ctl),
    .in_i  (in_i),
    .out_o (out_o)
  );

`ifndef SYNTHESIS
  // An accepted beat is followed by stall in the next cycle while it updates.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is still in work");

  // Every commit presents a result beat in the next cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> out_valid_o)
    else $error("committed item produced no result beat");

  // A hit never asks for a fetch.
  a_hit_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.hit && out_o.fetch_needed))
    else $error("result flags both hit and fetch");
`endif

endmodule
